[rtl/tvtd_pkg.sv]
`default_nettype none
package tvtd_pkg;

  localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CODE_MAX    = 21'h10FFFF;
  localparam logic [20:0] ESC_CODE    = 21'h00001B;
  localparam logic [20:0] BEL_CODE    = 21'h000007;
  localparam logic [20:0] CSI_C1      = 21'h00009B;
  localparam logic [20:0] ST_C1       = 21'h00009C;
  localparam logic [20:0] DCS_C1      = 21'h000090;
  localparam logic [20:0] SOS_C1      = 21'h000098;
  localparam logic [20:0] OSC_C1      = 21'h00009D;
  localparam logic [20:0] PM_C1       = 21'h00009E;
  localparam logic [20:0] APC_C1      = 21'h00009F;
  localparam logic [20:0] CH_LBRACKET = 21'h00005B;
  localparam logic [20:0] CH_RBRACKET = 21'h00005D;
  localparam logic [20:0] CH_UPPER_P  = 21'h000050;
  localparam logic [20:0] CH_UPPER_X  = 21'h000058;
  localparam logic [20:0] CH_CARET    = 21'h00005E;
  localparam logic [20:0] CH_UNDER    = 21'h00005F;
  localparam logic [20:0] CH_BSLASH   = 21'h00005C;

  localparam logic [2:0] SEQ_NONE  = 3'd0;
  localparam logic [2:0] SEQ_TWO   = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR  = 3'd4;

  localparam int MAX_FFFD = 4;

  typedef enum logic [5:0] {
    MODE_GROUND     = 6'b000001,
    MODE_ESC        = 6'b000010,
    MODE_CSI        = 6'b000100,
    MODE_STRING     = 6'b001000,
    MODE_STRING_ESC = 6'b010000,
    MODE_NF         = 6'b100000
  } esc_mode_t;

  typedef struct packed {
    logic [2:0]  fffd_count;
    logic        code_valid;
    logic [20:0] code;
    logic        last;
  } cp_item_t;

  typedef struct packed {
    esc_mode_t mode;
    logic      visible;
  } filt_state_t;

  function automatic logic is_space(input logic [20:0] c);
    return (c >= 21'h09 && c <= 21'h0D) || (c >= 21'h1C && c <= 21'h20) ||
           c == 21'h85 || c == 21'hA0 || c == 21'h1680 ||
           (c >= 21'h2000 && c <= 21'h200A) || c == 21'h2028 || c == 21'h2029 ||
           c == 21'h202F || c == 21'h205F || c == 21'h3000;
  endfunction

  function automatic logic is_visible(input logic [20:0] c);
    logic hidden;
    hidden = is_space(c) || c < 21'h20 || (c >= 21'h7F && c <= 21'h9F) ||
             (c >= 21'h200B && c <= 21'h200F) || (c >= 21'h202A && c <= 21'h202E) ||
             (c >= 21'h2060 && c <= 21'h206F) || c == 21'hFEFF;
    return !hidden;
  endfunction

  function automatic esc_mode_t string_code(input logic [20:0] c);
    esc_mode_t m;
    if (c == BEL_CODE || c == ST_C1) begin
      m = MODE_GROUND;
    end else if (c == ESC_CODE) begin
      m = MODE_STRING_ESC;
    end else begin
      m = MODE_STRING;
    end
    return m;
  endfunction

  function automatic filt_state_t filter_step(input filt_state_t s, input logic [20:0] c);
    filt_state_t r;
    r = s;
    unique case (s.mode)
      MODE_ESC: begin
        if (c == CH_LBRACKET) begin
          r.mode = MODE_CSI;
        end else if (c == CH_RBRACKET || c == CH_UPPER_P || c == CH_CARET ||
                     c == CH_UNDER || c == CH_UPPER_X) begin
          r.mode = MODE_STRING;
        end else if (c >= 21'h20 && c <= 21'h2F) begin
          r.mode = MODE_NF;
        end else begin
          r.mode = MODE_GROUND;
        end
      end
      MODE_CSI: begin
        if (c >= 21'h40 && c <= 21'h7E) r.mode = MODE_GROUND;
      end
      MODE_STRING: begin
        r.mode = string_code(c);
      end
      MODE_STRING_ESC: begin
        if (c == CH_BSLASH) begin
          r.mode = MODE_GROUND;
        end else begin
          r.mode = string_code(c);
        end
      end
      MODE_NF: begin
        if (c >= 21'h30 && c <= 21'h7E) r.mode = MODE_GROUND;
      end
      default: begin
        r.mode = MODE_GROUND;
        if (c == CSI_C1) begin
          r.mode = MODE_CSI;
        end else if (c == DCS_C1 || c == SOS_C1 || c == OSC_C1 || c == PM_C1 ||
                     c == APC_C1) begin
          r.mode = MODE_STRING;
        end else if (c == ESC_CODE) begin
          r.mode = MODE_ESC;
        end else if (is_visible(c)) begin
          r.visible = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/tvtd_byte_if.sv]
`default_nettype none
interface tvtd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

[rtl/tvtd_result_if.sv]
`default_nettype none
interface tvtd_result_if;
  logic valid;
  logic ready;
  logic has_visible;

  modport source (output valid, output has_visible, input ready);
  modport sink (input valid, input has_visible, output ready);
endinterface
`default_nettype wire

[rtl/tvtd_front.sv]
`default_nettype none
module tvtd_front
  import tvtd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  tvtd_byte_if.sink     bytes,
  output cp_item_t      push_item,
  output logic          push_valid,
  input  wire logic     push_ready
);

  logic [2:0]  seq_length, seq_length_next;
  logic [1:0]  seq_bytes_held, seq_bytes_held_next;
  logic [20:0] code_accum, code_accum_next;

  logic [7:0]  b;
  logic        cont;
  logic        do_start;
  logic        bad;
  logic [2:0]  held_ext;
  logic [2:0]  held_inc;
  logic [20:0] acc_shift;
  logic [20:0] minimum;
  cp_item_t    item;

  assign b         = bytes.data_byte;
  assign cont      = (b[7:6] == 2'b10);
  assign held_ext  = {1'b0, seq_bytes_held};
  assign held_inc  = held_ext + 3'd1;
  assign acc_shift = {code_accum[14:0], b[5:0]};
  assign minimum   = (seq_length == SEQ_TWO)   ? 21'h80 :
                     (seq_length == SEQ_THREE) ? 21'h800 : 21'h10000;
  assign bad       = acc_shift < minimum || acc_shift > CODE_MAX ||
                     (acc_shift >= 21'hD800 && acc_shift <= 21'hDFFF);

  always_comb begin
    item                = '0;
    item.last           = bytes.last_byte;
    seq_length_next     = seq_length;
    seq_bytes_held_next = seq_bytes_held;
    code_accum_next     = code_accum;
    do_start            = 1'b0;
    if (seq_length == SEQ_NONE) begin
      do_start = 1'b1;
    end else if (!cont) begin
      item.fffd_count     = held_ext;
      seq_length_next     = SEQ_NONE;
      seq_bytes_held_next = 2'd0;
      code_accum_next     = '0;
      do_start            = 1'b1;
    end else if (held_inc < seq_length) begin
      seq_bytes_held_next = held_inc[1:0];
      code_accum_next     = acc_shift;
    end else begin
      seq_length_next     = SEQ_NONE;
      seq_bytes_held_next = 2'd0;
      code_accum_next     = '0;
      if (bad) begin
        item.fffd_count = held_inc;
      end else begin
        item.code_valid = 1'b1;
        item.code       = acc_shift;
      end
    end
    if (do_start) begin
      priority if (!b[7]) begin
        item.code_valid = 1'b1;
        item.code       = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        seq_length_next     = SEQ_TWO;
        seq_bytes_held_next = 2'd1;
        code_accum_next     = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        seq_length_next     = SEQ_THREE;
        seq_bytes_held_next = 2'd1;
        code_accum_next     = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        seq_length_next     = SEQ_FOUR;
        seq_bytes_held_next = 2'd1;
        code_accum_next     = {18'd0, b[2:0]};
      end else begin
        item.code_valid = 1'b1;
        item.code       = REPLACEMENT;
      end
    end
    if (bytes.last_byte) begin
      item.fffd_count     = item.fffd_count + {1'b0, seq_bytes_held_next};
      seq_length_next     = SEQ_NONE;
      seq_bytes_held_next = 2'd0;
      code_accum_next     = '0;
    end
  end

  assign push_item   = item;
  assign push_valid  = bytes.valid;
  assign bytes.ready = push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_length     <= SEQ_NONE;
      seq_bytes_held <= 2'd0;
      code_accum     <= '0;
    end else if (bytes.valid && push_ready) begin
      seq_length     <= seq_length_next;
      seq_bytes_held <= seq_bytes_held_next;
      code_accum     <= code_accum_next;
    end
  end

endmodule
`default_nettype wire

[rtl/tvtd_queue.sv]
`default_nettype none
module tvtd_queue
  import tvtd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cp_item_t push_item,
  input  wire logic     push_valid,
  output logic          push_ready,
  output cp_item_t      pop_item,
  output logic          pop_valid,
  input  wire logic     pop_ready
);

  cp_item_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

[rtl/tvtd_back.sv]
`default_nettype none
module tvtd_back
  import tvtd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cp_item_t pop_item,
  input  wire logic     pop_valid,
  output logic          pop_ready,
  tvtd_result_if.source result
);

  filt_state_t st;
  filt_state_t st_next;
  logic        out_valid;
  logic        out_vis;
  logic        do_pop;

  always_comb begin
    st_next = st;
    for (int i = 0; i < MAX_FFFD; i++) begin
      if (3'(i) < pop_item.fffd_count) st_next = filter_step(st_next, REPLACEMENT);
    end
    if (pop_item.code_valid) st_next = filter_step(st_next, pop_item.code);
  end

  assign pop_ready          = !pop_item.last || !out_valid || result.ready;
  assign do_pop             = pop_valid && pop_ready;
  assign result.valid       = out_valid;
  assign result.has_visible = out_vis;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode    <= MODE_GROUND;
      st.visible <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (do_pop && pop_item.last) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (do_pop) begin
        if (pop_item.last) begin
          st.mode    <= MODE_GROUND;
          st.visible <= 1'b0;
        end else begin
          st <= st_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && pop_item.last) out_vis <= st_next.visible;
  end

endmodule
`default_nettype wire

[rtl/terminal_visible_text_detector.sv]
// Accepts one byte per cycle while the two-entry queue has room. The UTF-8 decoder
// writes each byte's item into the queue, and the escape filter retires up to four code
// points per byte from it and registers the result once the last byte's item is retired.
// Output is registered; while a result waits, bytes keep flowing until the next last byte
// and the byte after it fill the queue.
// Synchronous reset clears the decoder, the queue, the filter state and the output.
`default_nettype none
module terminal_visible_text_detector
  import tvtd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  tvtd_byte_if.sink     bytes,
  tvtd_result_if.source result
);

  cp_item_t push_item;
  logic     push_valid;
  logic     push_ready;
  cp_item_t pop_item;
  logic     pop_valid;
  logic     pop_ready;

  tvtd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  tvtd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  tvtd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_item  (pop_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .result    (result)
  );

endmodule
`default_nettype wire

[dv/testbench.sv]
`default_nettype none
module testbench;
  import tvtd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic       verdict;
  } byte_item_t;

  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS  = 550;
  localparam int PRESSURE_HOLD = 300;

  localparam int PH_STEADY      = 0;
  localparam int PH_SLOW_SOURCE = 1;
  localparam int PH_SLOW_SINK   = 2;
  localparam int PH_BOTH        = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tvtd_byte_if   bytes_if();
  tvtd_result_if result_if();

  terminal_visible_text_detector dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_if),
    .result (result_if)
  );

  always #5 clk = ~clk;

  // data, last, typed, verdict
  byte_item_t directed_rows [DIRECTED_ROWS] = '{
    {8'h41, 1'b1, 1'b1, 1'b1},
    {8'h20, 1'b1, 1'b1, 1'b0},
    {8'h00, 1'b1, 1'b1, 1'b0},
    {8'hFF, 1'b1, 1'b1, 1'b1},
    {8'h80, 1'b1, 1'b1, 1'b1},
    {8'hC0, 1'b0, 1'b0, 1'b0},
    {8'h80, 1'b1, 1'b1, 1'b1},
    {8'hED, 1'b0, 1'b0, 1'b0},
    {8'hA0, 1'b0, 1'b0, 1'b0},
    {8'h80, 1'b1, 1'b1, 1'b1},
    {8'hF5, 1'b0, 1'b0, 1'b0},
    {8'h80, 1'b0, 1'b0, 1'b0},
    {8'h80, 1'b0, 1'b0, 1'b0},
    {8'h80, 1'b1, 1'b1, 1'b1},
    {8'hE2, 1'b0, 1'b0, 1'b0},
    {8'h80, 1'b0, 1'b0, 1'b0},
    {8'h8B, 1'b1, 1'b1, 1'b0},
    {8'hE3, 1'b1, 1'b1, 1'b1},
    {8'hC2, 1'b0, 1'b0, 1'b0},
    {8'h9B, 1'b0, 1'b0, 1'b0},
    {8'h41, 1'b1, 1'b0, 1'b0},
    {8'h1B, 1'b0, 1'b0, 1'b0},
    {8'h28, 1'b0, 1'b0, 1'b0},
    {8'h42, 1'b1, 1'b0, 1'b0},
    {8'h1B, 1'b1, 1'b1, 1'b0}
  };

  byte_item_t  stream_q[$];
  logic [7:0]  text_buf[$];
  logic        verdict_q[$];

  int          send_idx = 0;
  int          taken_idx = 0;
  int          phase = PH_STEADY;
  int          fail_count = 0;
  logic        pressure_done = 1'b0;

  logic [2:0]  dec_len;
  logic [2:0]  dec_held;
  logic [20:0] dec_code;
  esc_mode_t   esc_mode;
  logic        text_seen;

  byte_item_t  seen_item;
  logic        want_visible;

  function automatic logic is_glyph(input logic [20:0] c);
    return !(c <= 21'h20 || (c >= 21'h7F && c <= 21'hA0) || c == 21'h1680 ||
             (c >= 21'h2000 && c <= 21'h200F) || (c >= 21'h2028 && c <= 21'h202F) ||
             (c >= 21'h205F && c <= 21'h206F) || c == 21'h3000 || c == 21'hFEFF);
  endfunction

  task automatic restart_text();
    dec_len   = SEQ_NONE;
    dec_held  = 3'd0;
    dec_code  = 21'd0;
    esc_mode  = MODE_GROUND;
    text_seen = 1'b0;
  endtask

  task automatic scan_code(input logic [20:0] c);
    case (esc_mode)
      MODE_ESC: begin
        if (c == CH_LBRACKET) begin
          esc_mode = MODE_CSI;
        end else if (c == CH_RBRACKET || c == CH_UPPER_P || c == CH_CARET ||
                     c == CH_UNDER || c == CH_UPPER_X) begin
          esc_mode = MODE_STRING;
        end else if (c >= 21'h20 && c <= 21'h2F) begin
          esc_mode = MODE_NF;
        end else begin
          esc_mode = MODE_GROUND;
        end
      end
      MODE_CSI: begin
        if (c >= 21'h40 && c <= 21'h7E) esc_mode = MODE_GROUND;
      end
      MODE_STRING, MODE_STRING_ESC: begin
        if (esc_mode == MODE_STRING_ESC && c == CH_BSLASH) begin
          esc_mode = MODE_GROUND;
        end else if (c == BEL_CODE || c == ST_C1) begin
          esc_mode = MODE_GROUND;
        end else if (c == ESC_CODE) begin
          esc_mode = MODE_STRING_ESC;
        end else begin
          esc_mode = MODE_STRING;
        end
      end
      MODE_NF: begin
        if (c >= 21'h30 && c <= 21'h7E) esc_mode = MODE_GROUND;
      end
      default: begin
        if (c == CSI_C1) begin
          esc_mode = MODE_CSI;
        end else if (c == DCS_C1 || c == SOS_C1 || c == OSC_C1 || c == PM_C1 ||
                     c == APC_C1) begin
          esc_mode = MODE_STRING;
        end else if (c == ESC_CODE) begin
          esc_mode = MODE_ESC;
        end else begin
          esc_mode = MODE_GROUND;
          if (is_glyph(c)) text_seen = 1'b1;
        end
      end
    endcase
  endtask

  task automatic drop_partial();
    int k;
    for (k = 0; k < dec_held; k++) scan_code(REPLACEMENT);
    dec_len  = SEQ_NONE;
    dec_held = 3'd0;
    dec_code = 21'd0;
  endtask

  task automatic take_lead(input logic [7:0] b);
    if (b < 8'h80) begin
      scan_code({13'd0, b});
    end else if (b[7:5] == 3'b110) begin
      dec_len  = SEQ_TWO;
      dec_held = 3'd1;
      dec_code = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      dec_len  = SEQ_THREE;
      dec_held = 3'd1;
      dec_code = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      dec_len  = SEQ_FOUR;
      dec_held = 3'd1;
      dec_code = {18'd0, b[2:0]};
    end else begin
      scan_code(REPLACEMENT);
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    logic [20:0] floor_code;
    logic [20:0] c;
    if (dec_len == SEQ_NONE) begin
      take_lead(b);
    end else if (b[7:6] != 2'b10) begin
      drop_partial();
      take_lead(b);
    end else begin
      dec_code = {dec_code[14:0], b[5:0]};
      dec_held = dec_held + 3'd1;
      if (dec_held == dec_len) begin
        floor_code = (dec_len == SEQ_TWO) ? 21'h80 :
                     (dec_len == SEQ_THREE) ? 21'h800 : 21'h10000;
        if (dec_code < floor_code || dec_code > CODE_MAX ||
            (dec_code >= 21'hD800 && dec_code <= 21'hDFFF)) begin
          drop_partial();
        end else begin
          c        = dec_code;
          dec_len  = SEQ_NONE;
          dec_held = 3'd0;
          dec_code = 21'd0;
          scan_code(c);
        end
      end
    end
  endtask

  task automatic put_b(input int unsigned v);
    text_buf.insert(text_buf.size(), v[7:0]);
  endtask

  task automatic put_cp(input int unsigned cp);
    if (cp < 32'h80) begin
      put_b(cp);
    end else if (cp < 32'h800) begin
      put_b(32'hC0 | (cp >> 6));
      put_b(32'h80 | (cp & 32'h3F));
    end else if (cp < 32'h10000) begin
      put_b(32'hE0 | (cp >> 12));
      put_b(32'h80 | ((cp >> 6) & 32'h3F));
      put_b(32'h80 | (cp & 32'h3F));
    end else begin
      put_b(32'hF0 | (cp >> 18));
      put_b(32'h80 | ((cp >> 12) & 32'h3F));
      put_b(32'h80 | ((cp >> 6) & 32'h3F));
      put_b(32'h80 | (cp & 32'h3F));
    end
  endtask

  task automatic put_any_cp();
    case ($urandom_range(0, 2))
      0: put_cp($urandom_range(32'h80, 32'h7FF));
      1: put_cp($urandom_range(0, 1) ? $urandom_range(32'h800, 32'hD7FF)
                                     : $urandom_range(32'hE000, 32'hFFFF));
      default: put_cp($urandom_range(32'h10000, 32'h10FFFF));
    endcase
  endtask

  task automatic put_hidden_cp();
    case ($urandom_range(0, 9))
      0: put_cp(32'hA0);
      1: put_cp(32'h85);
      2: put_cp(32'h1680);
      3: put_cp(32'h2000 + $urandom_range(0, 15));
      4: put_cp(32'h2028 + $urandom_range(0, 7));
      5: put_cp(32'h205F + $urandom_range(0, 16));
      6: put_cp(32'h3000);
      7: put_cp(32'hFEFF);
      8: put_cp(32'h80 + $urandom_range(0, 31));
      default: put_cp(32'h09 + $urandom_range(0, 4));
    endcase
  endtask

  task automatic put_broken();
    case ($urandom_range(0, 5))
      0: put_b($urandom_range(8'h80, 8'hBF));
      1: put_b($urandom_range(8'hF8, 8'hFF));
      2: begin
        if ($urandom_range(0, 1)) begin
          put_b($urandom_range(8'hC0, 8'hC1));
        end else begin
          put_b(8'hE0);
          put_b($urandom_range(8'h80, 8'h9F));
        end
        put_b($urandom_range(8'h80, 8'hBF));
      end
      3: begin
        put_b(8'hED);
        put_b($urandom_range(8'hA0, 8'hBF));
        put_b($urandom_range(8'h80, 8'hBF));
      end
      4: begin
        if ($urandom_range(0, 1)) begin
          put_b(8'hF4);
          put_b($urandom_range(8'h90, 8'hBF));
        end else begin
          put_b($urandom_range(8'hF5, 8'hF7));
          put_b($urandom_range(8'h80, 8'hBF));
        end
        put_b($urandom_range(8'h80, 8'hBF));
        put_b($urandom_range(8'h80, 8'hBF));
      end
      default: begin
        put_b($urandom_range(8'hC2, 8'hF4));
        if ($urandom_range(0, 1)) put_b($urandom_range(8'h80, 8'h8F));
        put_b($urandom_range(8'h00, 8'h7F));
      end
    endcase
  endtask

  task automatic put_control_string();
    int n;
    int k;
    if ($urandom_range(0, 1)) begin
      put_b(8'h1B);
      case ($urandom_range(0, 4))
        0: put_b(8'h5D);
        1: put_b(8'h50);
        2: put_b(8'h5E);
        3: put_b(8'h5F);
        default: put_b(8'h58);
      endcase
    end else begin
      put_b(8'hC2);
      case ($urandom_range(0, 4))
        0: put_b(8'h90);
        1: put_b(8'h98);
        2: put_b(8'h9D);
        3: put_b(8'h9E);
        default: put_b(8'h9F);
      endcase
    end
    n = $urandom_range(0, 5);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 5))
        0, 1, 2: put_b($urandom_range(8'h20, 8'h7E));
        3: put_cp($urandom_range(32'hA0, 32'h2FFF));
        4: begin
          put_b(8'h1B);
          put_b($urandom_range(8'h20, 8'h5B));
        end
        default: put_b($urandom_range(8'h00, 8'h1F));
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1, 2: put_b(8'h07);
      3, 4, 5: begin
        put_b(8'hC2);
        put_b(8'h9C);
      end
      6, 7, 8: begin
        put_b(8'h1B);
        put_b(8'h5C);
      end
      default: ;
    endcase
  endtask

  task automatic put_token(input bit quiet);
    int unsigned kind;
    int n;
    int k;
    kind = $urandom_range(0, 11);
    if (quiet && (kind == 0 || kind == 3 || kind >= 10)) kind = $urandom_range(1, 2);
    case (kind)
      0: put_b($urandom_range(8'h21, 8'h7E));
      1: put_b($urandom_range(0, 3) != 0 ? $urandom_range(8'h00, 8'h20) : 8'h7F);
      2: put_hidden_cp();
      3: put_any_cp();
      4, 5: begin
        if ($urandom_range(0, 1)) begin
          put_b(8'h1B);
          put_b(8'h5B);
        end else begin
          put_b(8'hC2);
          put_b(8'h9B);
        end
        n = $urandom_range(0, 4);
        for (k = 0; k < n; k++) put_b($urandom_range(8'h20, 8'h3F));
        put_b($urandom_range(8'h40, 8'h7E));
      end
      6, 7: put_control_string();
      8: begin
        put_b(8'h1B);
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) put_b($urandom_range(8'h20, 8'h2F));
        put_b($urandom_range(8'h30, 8'h7E));
      end
      9: begin
        put_b(8'h1B);
        put_b($urandom_range(8'h30, 8'h7E));
      end
      10: put_broken();
      default: put_b($urandom_range(8'h00, 8'hFF));
    endcase
  endtask

  task automatic add_string();
    bit quiet;
    int n;
    int k;
    byte_item_t it;
    quiet = $urandom_range(0, 1);
    n = $urandom_range(1, 6);
    text_buf.delete();
    for (k = 0; k < n; k++) put_token(quiet);
    if (!quiet && $urandom_range(0, 9) == 0) put_b($urandom_range(8'hC2, 8'hF4));
    for (k = 0; k < text_buf.size(); k++) begin
      it.data    = text_buf[k];
      it.last    = (k == text_buf.size() - 1);
      it.typed   = 1'b0;
      it.verdict = 1'b0;
      stream_q.insert(stream_q.size(), it);
    end
  endtask

  function automatic int phase_of(input int idx);
    if (idx < DIRECTED_ROWS + 140) return PH_STEADY;
    if (idx < DIRECTED_ROWS + 280) return PH_SLOW_SOURCE;
    if (idx < DIRECTED_ROWS + 420) return PH_SLOW_SINK;
    return PH_BOTH;
  endfunction

  function automatic int source_gap_pct(input int ph);
    case (ph)
      PH_SLOW_SOURCE: return 83;
      PH_BOTH:        return 26;
      default:        return 0;
    endcase
  endfunction

  function automatic int sink_stall_pct(input int ph);
    case (ph)
      PH_SLOW_SINK: return 83;
      PH_BOTH:      return 26;
      default:      return 0;
    endcase
  endfunction

  initial begin
    int k;
    bytes_if.valid     = 1'b0;
    bytes_if.data_byte = 8'h00;
    bytes_if.last_byte = 1'b0;
    restart_text();
    for (k = 0; k < DIRECTED_ROWS; k++) stream_q.insert(stream_q.size(), directed_rows[k]);
    while (stream_q.size() < DIRECTED_ROWS + RANDOM_ITEMS) add_string();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    for (send_idx = 0; send_idx < stream_q.size(); send_idx++) begin
      phase = phase_of(send_idx);
      while ($urandom_range(0, 99) < source_gap_pct(phase)) begin
        bytes_if.valid = 1'b0;
        @(negedge clk);
      end
      bytes_if.valid     = 1'b1;
      bytes_if.data_byte = stream_q[send_idx].data;
      bytes_if.last_byte = stream_q[send_idx].last;
      @(posedge clk);
      while (!bytes_if.ready) @(posedge clk);
      @(negedge clk);
    end
    bytes_if.valid = 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hold off the result side once so the input backs up
  initial begin
    int hold;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressure_done && !rst && phase == PH_STEADY &&
          send_idx >= DIRECTED_ROWS + 30) begin
        result_if.ready = 1'b0;
        for (hold = 0; hold < PRESSURE_HOLD; hold++) @(negedge clk);
        pressure_done = 1'b1;
      end
      result_if.ready = ($urandom_range(0, 99) >= sink_stall_pct(phase));
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (bytes_if.valid && bytes_if.ready) begin
        seen_item = stream_q[taken_idx];
        taken_idx++;
        absorb_byte(seen_item.data);
        if (seen_item.last) begin
          drop_partial();
          verdict_q.insert(verdict_q.size(),
                           seen_item.typed ? seen_item.verdict : text_seen);
          restart_text();
        end
      end
      if (result_if.valid && result_if.ready) begin
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result transaction: has_visible=%0b",
                     result_if.has_visible);
          end
        end else begin
          want_visible = verdict_q.pop_front();
          if (result_if.has_visible !== want_visible) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: has_visible expected %0b, got %0b",
                       want_visible, result_if.has_visible);
            end
          end
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
